>>> rtl/apr_pkg.sv
`default_nettype none
package apr_pkg;

  localparam int NumTagsDef    = 32;
  localparam int FieldCharsDef = 16;

  localparam logic signed [31:0] TxOffsetRst  = -32'sd19661;
  localparam logic [15:0]        TimeoutRst   = 16'd1000;
  localparam logic [31:0]        RyLimit      = 32'd11796480;  // 180.0 in Q16.16
  localparam logic [31:0]        RyWrap       = 32'd23592960;  // 360.0 in Q16.16
  localparam logic [16:0]        IpMax        = 17'd100000;

  localparam logic [7:0] ChStart = 8'h74;  // 't'
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic OpChar = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic CfgTxOffset = 1'b0;
  localparam logic CfgTimeout  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WS,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FSCAN,
    ST_FRAC,
    ST_STORE,
    ST_POSE,
    ST_AGE,
    ST_OUT
  } state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) ||
           (c == 8'd13);
  endfunction

endpackage
`default_nettype wire

>>> rtl/apr_ram.sv
`default_nettype none
module apr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/ascii_pose_record_parser.sv
`default_nettype none
// ASCII pose record parser. Takes one transaction per received character or
// millisecond tick and returns exactly one result transaction for each. A
// record is 't', seven comma-separated decimals (id, tx, ty, tz, rx, ry, rz)
// and a newline; fields become Q16.16. A comma or newline converts the
// buffered field by walking the character RAM one character per cycle, a
// newline that completes a record adds a pose update step, and a tick walks
// the tag table one tag per cycle. The block is busy (in_stall high) until
// its result is taken.
module ascii_pose_record_parser
  import apr_pkg::*;
#(
  parameter int NUM_TAGS    = apr_pkg::NumTagsDef,
  parameter int FIELD_CHARS = apr_pkg::FieldCharsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_pose_valid,
  output logic [4:0]              out_tag_id,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [31:0]      out_rot_x,
  output logic signed [31:0]      out_rot_y,
  output logic signed [31:0]      out_rot_z,
  output logic                    out_tracking,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);
  localparam int CW = $clog2(FIELD_CHARS);
  localparam int TW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
  localparam int KW = CW + 1;
  localparam logic [CW-1:0] CntMax = CW'(FIELD_CHARS - 1);
  // ceil(2^23 / 10): exact divide by ten for operands below 2^22
  localparam logic [40:0] Recip10 = 41'd838861;

  state_t state_r, state_nxt;

  logic signed [31:0] tx_offset_r;
  logic [15:0]        timeout_r;
  logic               in_record_r, in_record_nxt;
  logic [2:0]         fnum_r, fnum_nxt;
  logic [CW-1:0]      ccount_r, ccount_nxt;
  logic [31:0]        fval_r [7];
  logic [NUM_TAGS-1:0] det_r;
  logic [31:0]        seen_r [NUM_TAGS];
  logic [31:0]        now_r;
  logic [4:0]         last_r;
  logic [TW-1:0]      last_idx_r;
  logic               op_r;
  logic [7:0]         ch_r;

  // conversion datapath
  logic [KW-1:0]      idx_r, idx_nxt;   // scan pointer into field chars
  logic [KW-1:0]      fe_r, fe_nxt;     // fraction end
  logic [KW-1:0]      fs_r, fs_nxt;     // fraction start
  logic               neg_r, neg_nxt;
  logic [16:0]        ip_r, ip_nxt;
  logic [16:0]        carry_r, carry_nxt;
  logic [TW-1:0]      tag_r, tag_nxt;

  logic [CW-1:0] raddr;
  logic [7:0]    rdata;
  logic          ram_we;

  apr_ram #(.Width(8), .Depth(FIELD_CHARS)) u_chars (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ccount_r),
    .wdata(ch_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic [KW-1:0] n_chars;
  assign n_chars = {1'b0, ccount_r};

  // result register
  logic        out_valid_r;
  logic        pv_r;
  logic [4:0]  tid_r;
  logic [31:0] px_r, py_r, pz_r, rx_r, ry_r, rz_r;

  logic        accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  // shared magnitude math
  logic [20:0] ip_mul;
  logic [20:0] frac_t;
  logic [40:0] frac_p;
  logic [32:0] mag;
  logic [31:0] conv;
  logic [3:0]  dig;
  assign dig    = rdata[3:0];
  assign ip_mul = ({4'd0, ip_r} << 3) + ({4'd0, ip_r} << 1) + 21'(dig);
  assign frac_t = {1'b0, dig, 16'd0} + {4'd0, carry_r};
  // frac_t / 10 by reciprocal multiply
  assign frac_p = {20'd0, frac_t} * Recip10;
  assign mag    = {ip_r, 16'd0} + {16'd0, carry_r};
  always_comb begin
    if (neg_r) begin
      conv = (mag > 33'h80000000) ? 32'h80000000 : (32'd0 - mag[31:0]);
    end else begin
      conv = (mag > 33'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
  end

  // id rounding, ry wrap, tx offset
  logic signed [31:0] v0;
  logic [15:0]        rnd_pos, rnd_neg;
  logic               id_ok;
  logic [32:0]        negv;
  assign v0      = fval_r[0];
  assign negv    = 33'd0 - {v0[31], v0};
  assign rnd_pos = 16'(({1'b0, v0} + 33'h8000) >> 16);
  assign rnd_neg = 16'((negv + 33'h8000) >> 16);
  assign id_ok   = v0[31] ? (rnd_neg == 16'd0) : ({16'd0, rnd_pos} < 32'(NUM_TAGS));
  logic signed [32:0] sx;
  logic [31:0]        sat_x;
  assign sx = {fval_r[1][31], fval_r[1]} + {tx_offset_r[31], tx_offset_r};
  assign sat_x = (sx[32] != sx[31]) ? (sx[32] ? 32'h80000000 : 32'h7FFFFFFF) : sx[31:0];
  logic [31:0] ry_w;
  assign ry_w = ($signed(fval_r[5]) > $signed(RyLimit)) ? fval_r[5] - RyWrap : fval_r[5];
  logic [TW-1:0] id_idx;
  assign id_idx = TW'(rnd_pos);
  logic [31:0] age;
  assign age = now_r - seen_r[tag_r];

  // sequencer
  logic store_en, pose_en, age_en, res_load;
  always_comb begin
    state_nxt     = state_r;
    in_record_nxt = in_record_r;
    fnum_nxt      = fnum_r;
    ccount_nxt    = ccount_r;
    idx_nxt       = idx_r;
    fe_nxt        = fe_r;
    fs_nxt        = fs_r;
    neg_nxt       = neg_r;
    ip_nxt        = ip_r;
    carry_nxt     = carry_r;
    tag_nxt       = tag_r;
    raddr         = idx_r[CW-1:0];
    ram_we        = 1'b0;
    store_en      = 1'b0;
    pose_en       = 1'b0;
    age_en        = 1'b0;
    res_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          raddr   = '0;
          idx_nxt = '0;
          neg_nxt = 1'b0;
          ip_nxt  = '0;
          carry_nxt = '0;
          tag_nxt = '0;
          if (in_op == OpTick) begin
            state_nxt = ST_AGE;
          end else if (in_rx_byte == ChNl ||
                       (in_record_r && in_rx_byte == ChComma)) begin
            state_nxt = ST_WS;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_WS: begin
        if (idx_r < n_chars && is_ws(rdata)) begin
          idx_nxt = idx_r + 1'b1;
          raddr   = CW'(idx_r + 1'b1);
        end else begin
          state_nxt = ST_SIGN;
          raddr     = idx_r[CW-1:0];
        end
      end
      ST_SIGN: begin
        if (idx_r < n_chars && (rdata == ChPlus || rdata == ChMinus)) begin
          neg_nxt = (rdata == ChMinus);
          idx_nxt = idx_r + 1'b1;
          raddr   = CW'(idx_r + 1'b1);
        end
        state_nxt = ST_INT;
      end
      ST_INT: begin
        if (idx_r < n_chars && is_digit(rdata)) begin
          ip_nxt  = (ip_mul > {4'd0, IpMax}) ? IpMax : ip_mul[16:0];
          idx_nxt = idx_r + 1'b1;
          raddr   = CW'(idx_r + 1'b1);
        end else begin
          fs_nxt = idx_r;
          fe_nxt = idx_r;
          if (idx_r < n_chars && rdata == ChDot) begin
            idx_nxt = idx_r + 1'b1;
            fs_nxt  = idx_r + 1'b1;
            fe_nxt  = idx_r + 1'b1;
            raddr   = CW'(idx_r + 1'b1);
            state_nxt = ST_FSCAN;
          end else begin
            state_nxt = ST_STORE;
          end
        end
      end
      ST_FSCAN: begin
        if (idx_r < n_chars && is_digit(rdata)) begin
          idx_nxt = idx_r + 1'b1;
          fe_nxt  = idx_r + 1'b1;
          raddr   = CW'(idx_r + 1'b1);
        end else begin
          // walk fraction digits from last to first
          idx_nxt = fe_r;
          raddr   = CW'(fe_r - 1'b1);
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (idx_r > fs_r) begin
          carry_nxt = frac_p[39:23];
          idx_nxt   = idx_r - 1'b1;
          raddr     = CW'(idx_r - 2'd2);
        end else begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        store_en = 1'b1;
        if (ch_r == ChNl) begin
          state_nxt     = (fnum_r == 3'd6) ? ST_POSE : ST_OUT;
          in_record_nxt = 1'b0;
          fnum_nxt      = '0;
          ccount_nxt    = '0;
        end else begin
          ccount_nxt = '0;
          if (fnum_r < 3'd7) fnum_nxt = fnum_r + 3'd1;
          state_nxt = ST_OUT;
        end
      end
      ST_POSE: begin
        pose_en   = id_ok;
        state_nxt = ST_OUT;
      end
      ST_AGE: begin
        age_en = 1'b1;
        if (tag_r == TW'(NUM_TAGS - 1)) state_nxt = ST_OUT;
        else tag_nxt = tag_r + 1'b1;
      end
      ST_OUT: begin
        // plain character bookkeeping on the first pass
        if (!out_valid_r && !res_load) begin
          res_load = 1'b1;
          if (op_r == OpChar && ch_r != ChNl && ch_r != ChComma) begin
            if (!in_record_r) begin
              if (ch_r == ChStart) in_record_nxt = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ccount_nxt = (ccount_r == CntMax) ? CntMax : ccount_r + 1'b1;
            end
          end else if (op_r == OpChar && ch_r == ChComma && !in_record_r) begin
            // comma while waiting is ignored
          end
        end
        if (out_valid_r && !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_record_r <= 1'b0;
      fnum_r      <= '0;
      ccount_r    <= '0;
      det_r       <= '0;
      now_r       <= '0;
      last_r      <= '0;
      last_idx_r  <= '0;
      out_valid_r <= 1'b0;
      tx_offset_r <= TxOffsetRst;
      timeout_r   <= TimeoutRst;
      for (int i = 0; i < 7; i++) fval_r[i] <= '0;
      for (int i = 0; i < NUM_TAGS; i++) seen_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      in_record_r <= in_record_nxt;
      fnum_r      <= fnum_nxt;
      ccount_r    <= ccount_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgTxOffset) tx_offset_r <= cfg_data;
        else timeout_r <= cfg_data[15:0];
      end
      if (accept && in_op == OpTick) now_r <= now_r + 32'd1;
      if (store_en && fnum_r < 3'd7) fval_r[fnum_r] <= conv;
      if (pose_en) begin
        det_r[id_idx]  <= 1'b1;
        seen_r[id_idx] <= now_r;
        last_r         <= 5'(rnd_pos);
        last_idx_r     <= id_idx;
      end
      if (age_en && age > {16'd0, timeout_r}) det_r[tag_r] <= 1'b0;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      ch_r <= in_rx_byte;
    end
    idx_r   <= idx_nxt;
    fe_r    <= fe_nxt;
    fs_r    <= fs_nxt;
    neg_r   <= neg_nxt;
    ip_r    <= ip_nxt;
    carry_r <= carry_nxt;
    tag_r   <= tag_nxt;
    if (state_r == ST_IDLE && accept) pv_r <= 1'b0;
    if (pose_en) begin
      pv_r  <= 1'b1;
      tid_r <= 5'(rnd_pos);
      px_r  <= sat_x;
      py_r  <= fval_r[2];
      pz_r  <= fval_r[3];
      rx_r  <= fval_r[4];
      ry_r  <= ry_w;
      rz_r  <= fval_r[6];
    end
  end

  logic last_in_range;
  assign last_in_range = ({27'd0, last_r} < 32'(NUM_TAGS));

  assign out_valid      = out_valid_r;
  assign out_pose_valid = pv_r;
  assign out_tag_id     = pv_r ? tid_r : 5'd0;
  assign out_pos_x      = pv_r ? px_r : 32'd0;
  assign out_pos_y      = pv_r ? py_r : 32'd0;
  assign out_pos_z      = pv_r ? pz_r : 32'd0;
  assign out_rot_x      = pv_r ? rx_r : 32'd0;
  assign out_rot_y      = pv_r ? ry_r : 32'd0;
  assign out_rot_z      = pv_r ? rz_r : 32'd0;
  assign out_tracking   = last_in_range && det_r[last_idx_r];

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_fnum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (fnum_r <= 3'd7)) else $error("field count out of range");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
`endif
endmodule
`default_nettype wire

>>> sim/apr_pose_checker.sv
`timescale 1ns / 1ps
// Watches the character, result and register channels, keeps its own copy of
// the parser state and compares every result transaction with the oldest
// prediction.
module apr_pose_checker
  import apr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_pose_valid,
  input  wire logic [4:0]  out_tag_id,
  input  wire logic [31:0] out_pos_x,
  input  wire logic [31:0] out_pos_y,
  input  wire logic [31:0] out_pos_z,
  input  wire logic [31:0] out_rot_x,
  input  wire logic [31:0] out_rot_y,
  input  wire logic [31:0] out_rot_z,
  input  wire logic        out_tracking,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               errors,
  output int               pending
);

  localparam int NTAGS = NumTagsDef;
  localparam int NCHARS = FieldCharsDef;

  typedef struct packed {
    logic        pose_valid;
    logic [4:0]  tag_id;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] rot_x;
    logic [31:0] rot_y;
    logic [31:0] rot_z;
    logic        tracking;
  } pose_t;

  // shadow copy of the parser
  logic signed [31:0] offset_x;
  logic [15:0]        lost_after;
  logic               in_rec;
  logic [2:0]         fld_num;
  logic [3:0]         chr_cnt;
  logic [7:0]         fchars [NCHARS];
  logic [31:0]        fvals [7];
  logic               detected [NTAGS];
  logic [31:0]        seen_at [NTAGS];
  logic [31:0]        clock_ms;
  logic [4:0]         last_tag;

  pose_t pose_expect_q[$];

  function automatic logic [31:0] sat_q16(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // decimal text to Q16.16, fraction truncated
  function automatic logic [31:0] decimal_to_q16(input int n);
    int i, fs, fe, k;
    logic neg;
    longint unsigned ip, carry, mag, t;
    i = 0;
    neg = 1'b0;
    ip = 0;
    carry = 0;
    while (i < n && (fchars[i] == ChSpace || fchars[i] == 8'd9 || fchars[i] == 8'd11 ||
                     fchars[i] == 8'd12 || fchars[i] == 8'd13))
      i++;
    if (i < n && (fchars[i] == ChPlus || fchars[i] == ChMinus)) begin
      neg = (fchars[i] == ChMinus);
      i++;
    end
    while (i < n && fchars[i] >= "0" && fchars[i] <= "9") begin
      ip = ip * 10 + (fchars[i] - "0");
      if (ip > 100000) ip = 100000;
      i++;
    end
    fs = i;
    fe = i;
    if (i < n && fchars[i] == ChDot) begin
      fs = i + 1;
      fe = i + 1;
      while (fe < n && fchars[fe] >= "0" && fchars[fe] <= "9") fe++;
    end
    for (k = fe; k > fs; k--) begin
      t = (fchars[k-1] - "0") * 65536 + carry;
      carry = t / 10;
    end
    mag = ip * 65536 + carry;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // advance the shadow state by one transaction, return the expected result
  function automatic pose_t predict_pose(input logic op, input logic [7:0] c);
    pose_t r;
    longint v, rid, ry;
    r = '0;
    if (op == OpTick) begin
      clock_ms = clock_ms + 32'd1;
      for (int j = 0; j < NTAGS; j++)
        if (clock_ms - seen_at[j] > {16'd0, lost_after}) detected[j] = 1'b0;
    end else if (c == ChNl) begin
      if (fld_num < 7) fvals[fld_num] = decimal_to_q16(chr_cnt);
      if (fld_num == 6) begin
        v = longint'($signed(fvals[0]));
        rid = (v >= 0) ? (v + 32768) >>> 16 : -((-v + 32768) >>> 16);
        if (rid >= 0 && rid < NTAGS) begin
          ry = longint'($signed(fvals[5]));
          if (ry > 180 * 65536) ry = ry - 360 * 65536;
          detected[rid] = 1'b1;
          seen_at[rid] = clock_ms;
          last_tag = rid[4:0];
          r.pose_valid = 1'b1;
          r.tag_id = rid[4:0];
          r.pos_x = sat_q16(longint'($signed(fvals[1])) + longint'(offset_x));
          r.pos_y = fvals[2];
          r.pos_z = fvals[3];
          r.rot_x = fvals[4];
          r.rot_y = sat_q16(ry);
          r.rot_z = fvals[6];
        end
      end
      in_rec = 1'b0;
      fld_num = '0;
      chr_cnt = '0;
    end else if (!in_rec) begin
      if (c == ChStart) in_rec = 1'b1;
    end else if (c == ChComma) begin
      if (fld_num < 7) begin
        fvals[fld_num] = decimal_to_q16(chr_cnt);
        fld_num = fld_num + 3'd1;
      end
      chr_cnt = '0;
    end else begin
      fchars[chr_cnt] = c;
      if (chr_cnt < NCHARS - 1) chr_cnt = chr_cnt + 4'd1;
    end
    r.tracking = detected[last_tag];
    return r;
  endfunction

  function automatic int field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
             name, $signed(want), want, $signed(got), got);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    pose_t want;
    int ok;
    if (!rst_n) begin
      offset_x = TxOffsetRst;
      lost_after = TimeoutRst;
      in_rec = 1'b0;
      fld_num = '0;
      chr_cnt = '0;
      clock_ms = '0;
      last_tag = '0;
      errors = 0;
      pending = 0;
      for (int j = 0; j < 7; j++) fvals[j] = '0;
      for (int j = 0; j < NTAGS; j++) begin
        detected[j] = 1'b0;
        seen_at[j] = '0;
      end
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgTxOffset) offset_x = cfg_data;
        else lost_after = cfg_data[15:0];
      end
      // accepted character or tick
      if (in_valid && !in_stall) pose_expect_q.push_back(predict_pose(in_op, in_rx_byte));
      // accepted result
      if (out_valid && !out_stall) begin
        if (pose_expect_q.size() == 0) begin
          $error("result transaction with no prediction pending");
          errors++;
        end else begin
          want = pose_expect_q.pop_front();
          ok = 1;
          ok &= field_ok("pose_valid", want.pose_valid, out_pose_valid);
          ok &= field_ok("tag_id", want.tag_id, out_tag_id);
          ok &= field_ok("pos_x", want.pos_x, out_pos_x);
          ok &= field_ok("pos_y", want.pos_y, out_pos_y);
          ok &= field_ok("pos_z", want.pos_z, out_pos_z);
          ok &= field_ok("rot_x", want.rot_x, out_rot_x);
          ok &= field_ok("rot_y", want.rot_y, out_rot_y);
          ok &= field_ok("rot_z", want.rot_z, out_rot_z);
          ok &= field_ok("tracking", want.tracking, out_tracking);
          if (!ok) errors++;
        end
      end
      pending = pose_expect_q.size();
    end
  end

endmodule

>>> sim/ascii_pose_record_parser_tb.sv
`timescale 1ns / 1ps
module ascii_pose_record_parser_tb;
  import apr_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OpChar;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_pose_valid;
  logic [4:0]  out_tag_id;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_rot_x, out_rot_y, out_rot_z;
  logic        out_tracking;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CfgTxOffset;
  logic [31:0] cfg_data = '0;

  int errors, pending;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int sent_items = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  ascii_pose_record_parser u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_rx_byte,
    .out_valid, .out_stall, .out_pose_valid, .out_tag_id,
    .out_pos_x, .out_pos_y, .out_pos_z, .out_rot_x, .out_rot_y, .out_rot_z,
    .out_tracking, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  apr_pose_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_rx_byte,
    .out_valid, .out_stall, .out_pose_valid, .out_tag_id,
    .out_pos_x, .out_pos_y, .out_pos_z, .out_rot_x, .out_rot_y, .out_rot_z,
    .out_tracking, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  // receiver backpressure
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one character or tick transaction; stall is read at the falling edge
  task automatic send_item(input logic op, input logic [7:0] b);
    logic s;
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    do begin
      @(negedge clk);
      s = in_stall;
      @(posedge clk);
    end while (s);
    sent_items++;
  endtask

  task automatic send_text(input string txt, input int tick_pct);
    for (int i = 0; i < txt.len(); i++) begin
      if (tick_pct > 0 && $urandom_range(99) < tick_pct)
        send_item(OpTick, 8'($urandom_range(255)));
      send_item(OpChar, txt[i]);
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(OpTick, 8'($urandom_range(255)));
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    logic r;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
  endtask

  // drain, then write both registers
  task automatic reconfigure(input logic [31:0] offs, input logic [15:0] tmo);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    cfg_write(CfgTxOffset, offs);
    cfg_write(CfgTimeout, {16'd0, tmo});
    cfg_valid <= 1'b0;
  endtask

  function automatic string rand_digits(input int n);
    string s = "";
    repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  // a decimal field, occasionally with padding, odd signs or trailing junk
  function automatic string rand_number(input bit is_id);
    string s = "";
    int k = $urandom_range(99);
    if (k < 8) s = " ";
    else if (k < 11) s = $sformatf("%c%c", 8'd9, 8'd13);
    k = $urandom_range(99);
    if (k < (is_id ? 8 : 35)) s = {s, "-"};
    else if (k < 45) s = {s, "+"};
    if (is_id) s = {s, $sformatf("%0d", $urandom_range(0, 34))};
    else s = {s, rand_digits($urandom_range(99) < 5 ? $urandom_range(4, 9) : $urandom_range(0, 3))};
    if ($urandom_range(99) < 60) s = {s, ".", rand_digits($urandom_range(0, is_id ? 2 : 9))};
    if ($urandom_range(99) < 4) s = {s, "x9"};
    return s;
  endfunction

  function automatic string rand_record(input int nfields);
    string s = {"t", rand_number(1'b1)};
    for (int i = 1; i < nfields; i++) s = {s, ",", rand_number(1'b0)};
    return {s, "\n"};
  endfunction

  task automatic random_phase(input int n_items, input logic [31:0] offs, input logic [15:0] tmo,
                              input int gap, input int stall);
    int k;
    reconfigure(offs, tmo);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    n_items += sent_items;
    while (sent_items < n_items) begin
      k = $urandom_range(99);
      if (k < 72) send_text(rand_record(7), 2);
      else if (k < 80) send_ticks($urandom_range(1, 12));
      else if (k < 86) send_text(rand_record($urandom_range(1, 9)), 0);
      else if (k < 94) repeat ($urandom_range(1, 16)) send_item(OpChar, 8'($urandom_range(255)));
      else repeat ($urandom_range(1, 6))
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed records under reset settings
    send_text("t0,0,0,0,0,0,0\n", 0);
    send_text("t31,1.5,-2.25,+3,0.0000152587890625,180.0001,-0.5\n", 0);
    send_text("t32,1,1,1,1,1,1\n", 0);              // id out of range
    send_text("t-0.4,99999999,-99999999,.5,-.,+,179\n", 0);  // id rounds to zero
    send_text("t-1,1,1,1,1,1,1\n", 0);              // negative id
    send_text("t0.5,  12.5abc,\t-7,1234567890123456789,0,359.99,1\n", 0);
    send_text("t1,2,3,4,5,6,7,8\n", 0);             // too many fields
    send_text("t2,1,t,3\n", 0);                      // short record, 't' inside
    send_text("\nxyz\n", 0);                         // newline while waiting
    send_ticks(3);
    send_item(OpChar, 8'hFF);
    send_item(OpChar, 8'h00);

    random_phase(500, 32'h8000_0000, 16'd0, 0, 0);
    random_phase(500, 32'h7FFF_FFFF, 16'hFFFF, 49, 0);
    random_phase(500, 32'd0, 16'd3, 0, 49);
    random_phase(500, $urandom, 16'($urandom_range(1, 40)), 17, 17);

    in_valid <= 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/apr_pkg.sv
rtl/apr_ram.sv
rtl/ascii_pose_record_parser.sv
sim/apr_pose_checker.sv
sim/ascii_pose_record_parser_tb.sv
